// File: rtl/core/dbtp_pkg.sv
`default_nettype none

package dbtp_pkg;

  localparam int GRID_WIDTH  = 256;
  localparam int GRID_HEIGHT = 256;
  localparam int CELL_PIXELS = 4;
  localparam int MAX_RADIUS  = 15;

  // fixed field widths
  localparam int PTR_W     = 13;
  localparam int RADIUS_W  = 4;
  localparam int COLOR_W   = 32;
  localparam int KIND_W    = 2;
  localparam int COORD_W   = 8;
  localparam int CNT_W     = 10;
  localparam int CFG_IDX_W = 1;

  localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int ENTRY_W    = KIND_W + COLOR_W;

  localparam int CX_W  = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
  localparam int CY_W  = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
  localparam int RAD_W = $clog2(MAX_RADIUS + 1);
  localparam int DD_W  = RAD_W + 1;
  localparam int SQ_W  = 2 * DD_W;
  localparam int DIST_W = SQ_W + 1;
  localparam int XC_W  = ((CX_W > RAD_W) ? CX_W : RAD_W) + 2;
  localparam int YC_W  = ((CY_W > RAD_W) ? CY_W : RAD_W) + 2;

  // centre division by reciprocal multiply, exact for |diff| * CELL_PIXELS < 2**DIV_SH
  localparam int DIFF_W  = PTR_W + 1;
  localparam int DIV_SH  = DIFF_W + 5;
  localparam int DIV_MUL = (1 << DIV_SH) / CELL_PIXELS + 1;
  localparam int MUL_W   = DIV_SH + 1;
  localparam int PROD_W  = DIFF_W + MUL_W;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_AIR   = KIND_W'(0);
  localparam kind_t KIND_SAND  = KIND_W'(1);
  localparam kind_t KIND_SOLID = KIND_W'(2);

  localparam logic [COLOR_W-1:0] OPAQUE_BLACK = 32'h0000_00FF;

  localparam logic OP_STROKE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic              last;
    logic [ADDR_W-1:0] addr;
  } scan_t;

  // does the material rewrite a cell of kind k
  function automatic logic rule_hits(kind_t mat, kind_t k);
    logic hits;
    hits = 1'b0;
    case (mat)
      KIND_SAND:  hits = (k != KIND_SOLID) && (k != KIND_SAND);
      KIND_AIR:   hits = (k != KIND_AIR);
      KIND_SOLID: hits = (k == KIND_AIR);
      default:    hits = 1'b0;
    endcase
    return hits;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/dbtp_ram.sv
`default_nettype none

module dbtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/dbtp_scan.sv
`default_nettype none

module dbtp_scan
  import dbtp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [CX_W-1:0]  load_cx,
  input  logic [CY_W-1:0]  load_cy,
  input  logic [RAD_W-1:0] load_r,
  output scan_t            cur
);

  logic                    active;
  logic signed [DD_W-1:0]  dx;
  logic signed [DD_W-1:0]  dy;
  logic signed [DD_W-1:0]  r;
  logic [2*RAD_W-1:0]      r2;
  logic [CX_W-1:0]         cx;
  logic [CY_W-1:0]         cy;

  logic signed [SQ_W-1:0]  sqx;
  logic signed [SQ_W-1:0]  sqy;
  logic [DIST_W-1:0]       dsum;
  logic                    in_disc;
  logic signed [XC_W-1:0]  xs;
  logic signed [YC_W-1:0]  ys;
  logic                    in_grid;

  assign sqx     = dx * dx;
  assign sqy     = dy * dy;
  assign dsum    = DIST_W'($unsigned(sqx)) + DIST_W'($unsigned(sqy));
  assign in_disc = dsum <= DIST_W'(r2);

  assign xs = $signed(XC_W'(cx)) + XC_W'(dx);
  assign ys = $signed(YC_W'(cy)) + YC_W'(dy);
  assign in_grid = (xs >= 0) && (xs < $signed(XC_W'(GRID_WIDTH))) &&
                   (ys >= 0) && (ys < $signed(YC_W'(GRID_HEIGHT)));

  assign cur.valid = active;
  assign cur.hit   = active && in_disc && in_grid;
  assign cur.last  = active && (dx == r) && (dy == r);
  assign cur.addr  = ADDR_W'(ADDR_W'(ys[CY_W-1:0]) * ADDR_W'(GRID_WIDTH)) +
                     ADDR_W'(xs[CX_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= 1'b1;
    end else if (active && (dx == r) && (dy == r)) begin
      active <= 1'b0;
    end
  end

  // row-major walk over the bounding square of the disc
  always_ff @(posedge clk) begin
    if (load) begin
      r  <= $signed(DD_W'(load_r));
      r2 <= (2*RAD_W)'(load_r * load_r);
      dx <= -$signed(DD_W'(load_r));
      dy <= -$signed(DD_W'(load_r));
      cx <= load_cx;
      cy <= load_cy;
    end else if (active) begin
      if (dx == r) begin
        dx <= -r;
        dy <= dy + DD_W'(1);
      end else begin
        dx <= dx + DD_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/disc_brush_tile_painter.sv
`default_nettype none

// read: the done strobe is raised from the ST_READ state
// stroke with centre off the grid: the done strobe is raised from ST_CENTRE, with no scan
// stroke: ST_CENTRE then ST_SCAN, one ram read per cell of the bounding square and a ram
//   write for each cell that changes; one item at a time
// reset: a clearing pass over all GRID_WIDTH*GRID_HEIGHT cells (65536) holds busy high;
//   configuration writes are taken at any time; done cannot be stalled

module disc_brush_tile_painter
  import dbtp_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op,
  input  logic signed [PTR_W-1:0]     pointer_x,
  input  logic signed [PTR_W-1:0]     pointer_y,
  input  logic [RADIUS_W-1:0]         brush_radius,
  input  logic [COLOR_W-1:0]          paint_color,
  input  logic [KIND_W-1:0]           material,
  input  logic [COORD_W-1:0]          cell_x,
  input  logic [COORD_W-1:0]          cell_y,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic signed [PTR_W-1:0]     cfg_data,
  output logic                        done,
  output logic [KIND_W-1:0]           cell_kind,
  output logic [COLOR_W-1:0]          cell_color,
  output logic [CNT_W-1:0]            cells_changed,
  output logic                        centre_outside
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_CENTRE = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_READ   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic signed [PTR_W-1:0] canvas_offset_x;
  logic signed [PTR_W-1:0] canvas_offset_y;

  logic [ADDR_W-1:0]       clr_addr;
  logic                    accept;

  logic signed [PTR_W-1:0] px;
  logic signed [PTR_W-1:0] py;
  logic [RAD_W-1:0]        rad;
  logic [COLOR_W-1:0]      color;
  kind_t                   mat;
  logic                    rd_in_grid;
  logic [CNT_W-1:0]        cnt;

  // centre cell
  logic signed [DIFF_W-1:0] diff_x;
  logic signed [DIFF_W-1:0] diff_y;
  logic [DIFF_W-1:0]        mag_x;
  logic [DIFF_W-1:0]        mag_y;
  logic [PROD_W-1:0]        prod_x;
  logic [PROD_W-1:0]        prod_y;
  logic [DIFF_W-1:0]        q_x;
  logic [DIFF_W-1:0]        q_y;
  logic                     centre_ok;

  scan_t                    cur;
  logic                     scan_load;
  logic                     p1_valid;
  logic                     p1_hit;
  logic                     p1_last;
  logic [ADDR_W-1:0]        p1_addr;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]       ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]       ram_rdata;
  logic [ADDR_W-1:0]        idle_raddr;
  kind_t                    rd_kind;
  logic                     inc;
  logic                     scan_end;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_offset_x <= '0;
      canvas_offset_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OFFSET_X: canvas_offset_x <= cfg_data;
        CFG_OFFSET_Y: canvas_offset_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // truncating division toward zero: work on the magnitude, zero stays on the grid
  assign diff_x = DIFF_W'(px) - DIFF_W'(canvas_offset_x);
  assign diff_y = DIFF_W'(py) - DIFF_W'(canvas_offset_y);
  assign mag_x  = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
  assign mag_y  = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
  assign prod_x = PROD_W'(mag_x) * PROD_W'(DIV_MUL);
  assign prod_y = PROD_W'(mag_y) * PROD_W'(DIV_MUL);
  assign q_x    = prod_x[DIV_SH +: DIFF_W];
  assign q_y    = prod_y[DIV_SH +: DIFF_W];
  assign centre_ok = (!diff_x[DIFF_W-1] || (q_x == '0)) && (q_x < DIFF_W'(GRID_WIDTH)) &&
                     (!diff_y[DIFF_W-1] || (q_y == '0)) && (q_y < DIFF_W'(GRID_HEIGHT));

  assign scan_load = (state == ST_CENTRE) && centre_ok;

  dbtp_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .load    (scan_load),
    .load_cx (q_x[CX_W-1:0]),
    .load_cy (q_y[CY_W-1:0]),
    .load_r  (rad),
    .cur     (cur)
  );

  assign idle_raddr = ADDR_W'(ADDR_W'(cell_y) * ADDR_W'(GRID_WIDTH)) + ADDR_W'(cell_x);
  assign ram_raddr  = (state == ST_SCAN) ? cur.addr : idle_raddr;

  assign rd_kind  = ram_rdata[COLOR_W +: KIND_W];
  assign inc      = p1_valid && p1_hit && rule_hits(mat, rd_kind);
  assign scan_end = p1_valid && p1_last;

  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = {KIND_AIR, OPAQUE_BLACK};
    end else begin
      ram_we    = (state == ST_SCAN) && inc;
      ram_waddr = p1_addr;
      ram_wdata = {mat, (mat == KIND_AIR) ? OPAQUE_BLACK : color};
    end
  end

  dbtp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_addr == ADDR_W'(CELL_COUNT - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (start) state_next = (op == OP_READ) ? ST_READ : ST_CENTRE;
      ST_CENTRE: state_next = centre_ok ? ST_SCAN : ST_IDLE;
      ST_SCAN:   if (scan_end) state_next = ST_IDLE;
      ST_READ:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      done     <= 1'b0;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (((state == ST_CENTRE) && !centre_ok) || ((state == ST_SCAN) && scan_end) ||
          (state == ST_READ)) begin
        done <= 1'b1;
      end
    end
  end

  // item capture and stroke pipeline
  always_ff @(posedge clk) begin
    if (accept) begin
      px         <= pointer_x;
      py         <= pointer_y;
      rad        <= (32'(brush_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
                                                     : RAD_W'(brush_radius);
      color      <= paint_color;
      mat        <= material;
      rd_in_grid <= (32'(cell_x) < GRID_WIDTH) && (32'(cell_y) < GRID_HEIGHT);
    end
    p1_valid <= (state == ST_SCAN) && cur.valid;
    p1_hit   <= cur.hit;
    p1_last  <= cur.last;
    p1_addr  <= cur.addr;
    if (state == ST_CENTRE) begin
      cnt <= '0;
    end else if (inc) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_CENTRE: begin
        cell_kind      <= KIND_AIR;
        cell_color     <= '0;
        cells_changed  <= '0;
        centre_outside <= 1'b1;
      end
      ST_SCAN: begin
        cell_kind      <= KIND_AIR;
        cell_color     <= '0;
        cells_changed  <= cnt + CNT_W'(inc);
        centre_outside <= 1'b0;
      end
      ST_READ: begin
        cell_kind      <= rd_in_grid ? rd_kind : KIND_AIR;
        cell_color     <= rd_in_grid ? ram_rdata[COLOR_W-1:0] : '0;
        cells_changed  <= '0;
        centre_outside <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/dbtp_checker.sv
`default_nettype none

module dbtp_checker
  import dbtp_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        done,
  input  logic [KIND_W-1:0]           cell_kind,
  input  logic [COLOR_W-1:0]          cell_color,
  input  logic [CNT_W-1:0]            cells_changed,
  input  logic                        centre_outside
);

  // the clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> busy && !done)
    else $error("block not busy after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_outside_empty: assert property (@(posedge clk) disable iff (rst)
    done && centre_outside |-> (cells_changed == '0) && (cell_kind == '0) &&
                               (cell_color == '0))
    else $error("ignored stroke reported a change");

endmodule

bind disc_brush_tile_painter dbtp_checker u_dbtp_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .cell_kind      (cell_kind),
  .cell_color     (cell_color),
  .cells_changed  (cells_changed),
  .centre_outside (centre_outside)
);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import dbtp_pkg::*;

  localparam int CYCLE_LIMIT   = 4000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 96;
  localparam int PHASE_COUNT   = 6;

  // material code that leaves every cell alone
  localparam kind_t KIND_INERT = KIND_W'(3);

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic                    op;
  logic signed [PTR_W-1:0] pointer_x;
  logic signed [PTR_W-1:0] pointer_y;
  logic [RADIUS_W-1:0]     brush_radius;
  logic [COLOR_W-1:0]      paint_color;
  logic [KIND_W-1:0]       material;
  logic [COORD_W-1:0]      cell_x;
  logic [COORD_W-1:0]      cell_y;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic signed [PTR_W-1:0] cfg_data;
  logic                    done;
  logic [KIND_W-1:0]       cell_kind;
  logic [COLOR_W-1:0]      cell_color;
  logic [CNT_W-1:0]        cells_changed;
  logic                    centre_outside;

  int cycles = 0;
  int hot_x = 128;
  int hot_y = 128;

  typedef struct {
    kind_t              kind;
    logic [COLOR_W-1:0] color;
    logic [CNT_W-1:0]   changed;
    logic               outside;
  } paint_result_t;

  class paint_scoreboard;
    kind_t              kind_map [CELL_COUNT];
    logic [COLOR_W-1:0] color_map [CELL_COUNT];
    int                 off_x;
    int                 off_y;
    int                 errors;
    paint_result_t      pending_results [$];

    function new();
      for (int i = 0; i < CELL_COUNT; i++) begin
        kind_map[i]  = KIND_AIR;
        color_map[i] = OPAQUE_BLACK;
      end
      off_x  = 0;
      off_y  = 0;
      errors = 0;
    endfunction

    function void set_offset(logic [CFG_IDX_W-1:0] idx, logic signed [PTR_W-1:0] value);
      if (idx == CFG_OFFSET_X) begin
        off_x = value;
      end else begin
        off_y = value;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void note_item(logic o, logic signed [PTR_W-1:0] px, logic signed [PTR_W-1:0] py,
                            logic [RADIUS_W-1:0] r, logic [COLOR_W-1:0] col, kind_t mat,
                            logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      paint_result_t res;
      int            cx;
      int            cy;
      int            rad;
      int            gx;
      int            gy;
      int            idx;
      int            count;
      kind_t         k;
      logic          hit;
      res.kind    = KIND_AIR;
      res.color   = '0;
      res.changed = '0;
      res.outside = 1'b0;
      if (o == OP_READ) begin
        if (int'(x) < GRID_WIDTH && int'(y) < GRID_HEIGHT) begin
          idx       = int'(y) * GRID_WIDTH + int'(x);
          res.kind  = kind_map[idx];
          res.color = color_map[idx];
        end
      end else begin
        // int division truncates toward zero, so small negative offsets land on 0
        cx  = (int'(px) - off_x) / CELL_PIXELS;
        cy  = (int'(py) - off_y) / CELL_PIXELS;
        rad = int'(r);
        if (rad > MAX_RADIUS) rad = MAX_RADIUS;
        if (cx < 0 || cx >= GRID_WIDTH || cy < 0 || cy >= GRID_HEIGHT) begin
          res.outside = 1'b1;
        end else begin
          count = 0;
          for (int dy = -rad; dy <= rad; dy++) begin
            for (int dx = -rad; dx <= rad; dx++) begin
              gx = cx + dx;
              gy = cy + dy;
              if (dx * dx + dy * dy > rad * rad) continue;
              if (gx < 0 || gx >= GRID_WIDTH || gy < 0 || gy >= GRID_HEIGHT) continue;
              idx = gy * GRID_WIDTH + gx;
              k   = kind_map[idx];
              case (mat)
                KIND_SAND:  hit = (k != KIND_SOLID) && (k != KIND_SAND);
                KIND_AIR:   hit = (k != KIND_AIR);
                KIND_SOLID: hit = (k == KIND_AIR);
                default:    hit = 1'b0;
              endcase
              if (hit) begin
                kind_map[idx]  = mat;
                color_map[idx] = (mat == KIND_AIR) ? OPAQUE_BLACK : col;
                count++;
              end
            end
          end
          res.changed = count[CNT_W-1:0];
        end
      end
      pending_results.push_back(res);
    endfunction

    function void report(string what, logic [63:0] want_v, logic [63:0] got_v);
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, what, want_v, got_v);
    endfunction

    function void check_result(kind_t kind, logic [COLOR_W-1:0] color,
                               logic [CNT_W-1:0] changed, logic outside);
      paint_result_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result beat, cells_changed", '0, 64'(changed));
        return;
      end
      want = pending_results.pop_front();
      if (kind !== want.kind) report("cell_kind", 64'(want.kind), 64'(kind));
      if (color !== want.color) report("cell_color", 64'(want.color), 64'(color));
      if (changed !== want.changed) report("cells_changed", 64'(want.changed), 64'(changed));
      if (outside !== want.outside) report("centre_outside", 64'(want.outside), 64'(outside));
    endfunction
  endclass

  paint_scoreboard sb;

  disc_brush_tile_painter u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .pointer_x      (pointer_x),
    .pointer_y      (pointer_y),
    .brush_radius   (brush_radius),
    .paint_color    (paint_color),
    .material       (material),
    .cell_x         (cell_x),
    .cell_y         (cell_y),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .cell_kind      (cell_kind),
    .cell_color     (cell_color),
    .cells_changed  (cells_changed),
    .centre_outside (centre_outside)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(cell_kind, cell_color, cells_changed, centre_outside);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(logic o, int px, int py, int r, logic [COLOR_W-1:0] col, int mat,
                           int x, int y);
    @(negedge clk);
    start        <= 1'b1;
    op           <= o;
    pointer_x    <= PTR_W'(px);
    pointer_y    <= PTR_W'(py);
    brush_radius <= RADIUS_W'(r);
    paint_color  <= col;
    material     <= KIND_W'(mat);
    cell_x       <= COORD_W'(x);
    cell_y       <= COORD_W'(y);
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(op, pointer_x, pointer_y, brush_radius, paint_color, material, cell_x, cell_y);
  endtask

  task automatic stroke(int px, int py, int r, logic [COLOR_W-1:0] col, int mat);
    send_item(OP_STROKE, px, py, r, col, mat, $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  task automatic read_cell(int x, int y);
    send_item(OP_READ, int'($urandom_range(0, 8191)) - 4096, int'($urandom_range(0, 8191)) - 4096,
              $urandom_range(0, 15), $urandom, $urandom_range(0, 3), x, y);
  endtask

  task automatic idle(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_offset(logic [CFG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= PTR_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_offset(cfg_index, cfg_data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // pixel position that mostly lands on or just beside the grid
  function automatic int aim(int off);
    int diff;
    int p;
    case ($urandom_range(0, 9))
      0:          diff = -int'($urandom_range(1, 7));
      1:          diff = 1020 + int'($urandom_range(0, 11));
      2, 3, 4, 5: diff = (120 + int'($urandom_range(0, 15))) * CELL_PIXELS
                         + int'($urandom_range(0, 3));
      6:          diff = $urandom_range(0, 63);
      7:          diff = 960 + int'($urandom_range(0, 63));
      default:    diff = $urandom_range(0, 1023);
    endcase
    p = off + diff;
    if (p < -4096 || p > 4095) p = int'($urandom_range(0, 8191)) - 4096;
    return p;
  endfunction

  task automatic random_item();
    int px;
    int py;
    int r;
    int sel;
    int mat;
    if ($urandom_range(0, 99) < 40) begin
      if ($urandom_range(0, 4) == 0) begin
        read_cell($urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
        read_cell((hot_x + int'($urandom_range(0, 30)) - 15) & 8'hFF,
                  (hot_y + int'($urandom_range(0, 30)) - 15) & 8'hFF);
      end
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 70) r = $urandom_range(0, 4);
      else if (sel < 95) r = $urandom_range(5, 10);
      else r = $urandom_range(11, 15);
      if ($urandom_range(0, 9) == 0) begin
        px = int'($urandom_range(0, 8191)) - 4096;
        py = int'($urandom_range(0, 8191)) - 4096;
      end else begin
        px = aim(sb.off_x);
        py = aim(sb.off_y);
      end
      if ((px - sb.off_x) >= 0 && (px - sb.off_x) / CELL_PIXELS < GRID_WIDTH &&
          (py - sb.off_y) >= 0 && (py - sb.off_y) / CELL_PIXELS < GRID_HEIGHT) begin
        hot_x = (px - sb.off_x) / CELL_PIXELS;
        hot_y = (py - sb.off_y) / CELL_PIXELS;
      end
      mat = ($urandom_range(0, 9) == 0) ? KIND_INERT : $urandom_range(0, 2);
      stroke(px, py, r, $urandom, mat);
    end
  endtask

  task automatic run_phase(int items, bit gaps);
    int left;
    int burst;
    left = items;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && left > 0) begin
        random_item();
        burst--;
        left--;
      end
      if (gaps) idle($urandom_range(0, 6));
    end
  endtask

  initial begin
    sb           = new();
    rst          = 1'b1;
    start        = 1'b0;
    op           = OP_STROKE;
    pointer_x    = '0;
    pointer_y    = '0;
    brush_radius = '0;
    paint_color  = '0;
    material     = KIND_AIR;
    cell_x       = '0;
    cell_y       = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_OFFSET_X;
    cfg_data     = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset contents, then overlapping discs of every material
    read_cell(0, 0);
    read_cell(255, 255);
    stroke(40, 40, 0, 32'hFFFF_FFFF, KIND_SAND);
    read_cell(10, 10);
    stroke(40, 40, 15, 32'h0000_0000, KIND_SOLID);
    read_cell(10, 10);
    read_cell(10, 25);
    stroke(40, 40, 15, 32'h1234_5678, KIND_INERT);
    stroke(0, 0, 15, 32'hA5A5_5A5A, KIND_SAND);
    stroke(1023, 1023, 15, 32'h0F0F_F0F0, KIND_AIR);
    stroke(1023, 1023, 7, 32'hFFFF_FFFF, KIND_SOLID);
    stroke(1023, 1023, 15, 32'h0000_0000, KIND_AIR);
    stroke(40, 40, 15, 32'h0000_0000, KIND_AIR);
    // centre just left of and above the grid truncates onto row and column 0
    stroke(-3, -1, 2, 32'hCAFE_0001, KIND_SAND);
    read_cell(0, 0);
    stroke(-4, 0, 3, 32'hCAFE_0002, KIND_SAND);
    stroke(4095, 0, 3, 32'hCAFE_0003, KIND_SAND);
    stroke(-4096, -4096, 15, 32'hCAFE_0004, KIND_SOLID);
    stroke(0, 1024, 15, 32'hCAFE_0005, KIND_SOLID);
    wait_idle();

    write_offset(CFG_OFFSET_X, -4096);
    write_offset(CFG_OFFSET_Y, 4095);
    stroke(-4096, 4095, 3, 32'h8000_0001, KIND_SAND);
    stroke(-3073, 4092, 15, 32'h7FFF_FFFE, KIND_SOLID);
    stroke(-3072, 4095, 1, 32'h1111_1111, KIND_SAND);
    read_cell(255, 0);
    wait_idle();

    write_offset(CFG_OFFSET_X, 4095);
    write_offset(CFG_OFFSET_Y, -4096);
    stroke(4095, -4096, 15, 32'h2222_2222, KIND_AIR);
    read_cell(0, 0);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_offset(CFG_OFFSET_X, 0);
          write_offset(CFG_OFFSET_Y, 0);
        end
        2, 5: begin
          write_offset(CFG_OFFSET_X, int'($urandom_range(0, 128)) - 64);
          write_offset(CFG_OFFSET_Y, int'($urandom_range(0, 128)) - 64);
        end
        3: begin
          write_offset(CFG_OFFSET_X, 4095);
          write_offset(CFG_OFFSET_Y, -4096);
        end
        default: begin
          write_offset(CFG_OFFSET_X, int'($urandom_range(0, 8191)) - 4096);
          write_offset(CFG_OFFSET_Y, int'($urandom_range(0, 8191)) - 4096);
        end
      endcase
      // one phase runs back to back with no gaps
      run_phase(PHASE_ITEMS, p != 2);
    end

    wait_idle();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
